>>> rtl/core/bdeq_pkg.sv
// Shared constants, types and ring arithmetic for the bounded double-ended queue.
package bdeq_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_W      = 32;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef struct packed {
        logic apply;
        logic read;
        logic load;
    } bdeq_ctl_t;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(ptr) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

>>> rtl/core/bdeq_ifs.sv
// Handshake interfaces for the operation and result channels.
interface bdeq_cmd_if import bdeq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    op_t                      op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface bdeq_rsp_if import bdeq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     op_error;

    modport source (output valid, output front_value, output back_value,
                    output entry_count, output is_empty, output is_full,
                    output op_error, input ready);
    modport sink (input valid, input front_value, input back_value,
                  input entry_count, input is_empty, input is_full,
                  input op_error, output ready);
endinterface

>>> rtl/core/bdeq_ctrl.sv
// Sequencing state machine for the bounded double-ended queue.
module bdeq_ctrl import bdeq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output bdeq_ctl_t ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd_ready      = (state_reg == S_IDLE);
        ctl.apply      = (state_reg == S_IDLE) && cmd_valid;
        ctl.read       = (state_reg == S_READ);
        ctl.load       = (state_reg == S_LOAD) && (!out_valid_reg || rsp_ready);
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (ctl.load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    a_apply_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.apply |=> state_reg == S_READ)
        else $error("accepted transaction did not move to the read step");

    a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) && out_valid_reg && !rsp_ready |=> state_reg == S_LOAD)
        else $error("result register overwritten before it was taken");

endmodule

>>> rtl/core/bdeq_dp.sv
// Ring storage, pointer and count registers, and result register of the deque.
module bdeq_dp import bdeq_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdeq_ctl_t                ctl,
    input  op_t                      op,
    input  logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] back_value,
    output logic [COUNT_OUT_W-1:0]   entry_count,
    output logic                     is_empty,
    output logic                     is_full,
    output logic                     op_error
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]         front_reg;
    logic [PTR_W-1:0]         front_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     err_reg;
    logic                     err_next;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    logic [PTR_W-1:0]         front_dec;
    logic [PTR_W-1:0]         front_inc;
    logic [PTR_W-1:0]         back_addr;
    logic [CNT_W-1:0]         last_offset;
    logic                     cur_full;
    logic                     cur_empty;
    logic signed [DATA_W-1:0] rd_front_reg;
    logic signed [DATA_W-1:0] rd_back_reg;
    logic signed [DATA_W-1:0] front_value_reg;
    logic signed [DATA_W-1:0] back_value_reg;
    logic [COUNT_OUT_W-1:0]   entry_count_reg;
    logic                     is_empty_reg;
    logic                     is_full_reg;
    logic                     op_error_reg;

    always_comb
    begin
        cur_full    = (count_reg == CNT_W'(DEPTH));
        cur_empty   = (count_reg == '0);
        front_dec   = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
        front_inc   = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
        last_offset = cur_empty ? '0 : count_reg - 1'b1;
        back_addr   = ring_add(front_reg, last_offset);
        front_next  = front_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        wr_en       = 1'b0;
        wr_addr     = front_dec;
        if (ctl.apply)
        begin
            err_next = 1'b0;
            case (op)
                OP_PUSH_FRONT:
                begin
                    if (cur_full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (cur_full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ring_add(front_reg, count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (cur_empty)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (cur_empty)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.read)
        begin
            rd_front_reg <= mem[front_reg];
            rd_back_reg  <= mem[back_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            front_value_reg <= cur_empty ? '0 : rd_front_reg;
            back_value_reg  <= cur_empty ? '0 : rd_back_reg;
            entry_count_reg <= COUNT_OUT_W'(count_reg);
            is_empty_reg    <= cur_empty;
            is_full_reg     <= cur_full;
            op_error_reg    <= err_reg;
        end
    end

    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;
    assign op_error    = op_error_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the ring depth");

    a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.apply && err_next |=> (count_reg == $past(count_reg))
                                  && (front_reg == $past(front_reg)))
        else $error("rejected transaction changed the deque");

endmodule

>>> rtl/core/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: controller, datapath and channel wiring.
// A ring of 16 signed 32-bit entries with push and pop at either end. Each transaction on
// cmd produces exactly one transaction on rsp describing the deque after the operation;
// a push when full or a pop when empty leaves the deque untouched and sets op_error.
// An operation runs through its steps in order: update and write, registered read of the two end
// entries from the storage array, load of the result register. The load waits while an earlier
// result has not yet been taken on rsp. cmd is taken again as soon as the result register is
// loaded, while that result still waits on rsp.
module bounded_double_ended_queue import bdeq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bdeq_cmd_if.sink   cmd,
    bdeq_rsp_if.source rsp
);

    bdeq_ctl_t ctl;
    logic      cmd_ready;
    logic      rsp_valid;

    bdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    bdeq_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .op          (cmd.op),
        .value       (cmd.value),
        .front_value (rsp.front_value),
        .back_value  (rsp.back_value),
        .entry_count (rsp.entry_count),
        .is_empty    (rsp.is_empty),
        .is_full     (rsp.is_full),
        .op_error    (rsp.op_error)
    );

    assign cmd.ready = cmd_ready;
    assign rsp.valid = rsp_valid;

endmodule

>>> dv/bounded_double_ended_queue_tb.sv
// Self-checking testbench for the bounded double-ended queue, with directed and random traffic.
`timescale 1ns / 1ps

module bounded_double_ended_queue_tb import bdeq_pkg::*; ();

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     is_empty;
        logic                     is_full;
        logic                     op_error;
    } deque_view_t;

    typedef struct {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        deque_view_t              want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bdeq_cmd_if cmd ();
    bdeq_rsp_if rsp ();

    bounded_double_ended_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    logic signed [DATA_W-1:0] ring_mem [DEPTH];
    int                       ring_head;
    int                       ring_fill;

    deque_view_t expected_views [$];
    stim_row_t   stim_table [$];

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int mismatch_count;
    int views_checked;
    int pushes_sent;
    int pops_sent;
    int rejects_sent;
    int full_reached;

    deque_view_t got_view;
    deque_view_t want_view;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic deque_view_t apply_deque_op(input op_t op,
                                                  input logic signed [DATA_W-1:0] value);
        deque_view_t view;
        logic        rejected;
        rejected = 1'b0;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (ring_fill >= DEPTH)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_mem[ring_head] = value;
                    ring_fill++;
                end
            end
            OP_PUSH_BACK:
            begin
                if (ring_fill >= DEPTH)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    ring_mem[(ring_head + ring_fill) % DEPTH] = value;
                    ring_fill++;
                end
            end
            OP_POP_FRONT:
            begin
                if (ring_fill == 0)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            default:
            begin
                if (ring_fill == 0)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    ring_fill--;
                end
            end
        endcase
        if (ring_fill == 0)
        begin
            view.front_value = '0;
            view.back_value  = '0;
        end
        else
        begin
            view.front_value = ring_mem[ring_head];
            view.back_value  = ring_mem[(ring_head + ring_fill - 1) % DEPTH];
        end
        view.entry_count = COUNT_OUT_W'(ring_fill);
        view.is_empty    = (ring_fill == 0);
        view.is_full     = (ring_fill >= DEPTH);
        view.op_error    = rejected;
        return view;
    endfunction

    function automatic void add_row(input op_t op, input logic signed [DATA_W-1:0] value,
                                    input bit typed, input deque_view_t want);
        stim_row_t row;
        row.op    = op;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endfunction

    task automatic send_transaction(input op_t op, input logic signed [DATA_W-1:0] value,
                                    input bit typed, input deque_view_t want);
        deque_view_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.op    <= op;
        cmd.value <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cmd.ready);
        predicted = apply_deque_op(op, value);
        expected_views.push_back(typed ? want : predicted);
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            pushes_sent++;
        end
        else
        begin
            pops_sent++;
        end
        if (predicted.op_error)
        begin
            rejects_sent++;
        end
        if (predicted.is_full)
        begin
            full_reached++;
        end
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        cmd.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (expected_views.size() != 0);
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got_view.front_value = rsp.front_value;
            got_view.back_value  = rsp.back_value;
            got_view.entry_count = rsp.entry_count;
            got_view.is_empty    = rsp.is_empty;
            got_view.is_full     = rsp.is_full;
            got_view.op_error    = rsp.op_error;
            if (expected_views.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %p",
                         $time, got_view);
                mismatch_count++;
            end
            else
            begin
                want_view = expected_views.pop_front();
                check_field("front_value", want_view.front_value, got_view.front_value);
                check_field("back_value", want_view.back_value, got_view.back_value);
                check_field("entry_count", want_view.entry_count, got_view.entry_count);
                check_field("is_empty", want_view.is_empty, got_view.is_empty);
                check_field("is_full", want_view.is_full, got_view.is_full);
                check_field("op_error", want_view.op_error, got_view.op_error);
                views_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bounded_double_ended_queue_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        deque_view_t none;
        deque_view_t empty_err;
        logic signed [DATA_W-1:0] max_val;
        logic signed [DATA_W-1:0] min_val;
        logic signed [DATA_W-1:0] value;
        op_t                      op;
        int                       push_bias;
        int                       burst_left;
        int                       phase;
        int                       i;

        cmd.valid      <= 1'b0;
        cmd.op         <= OP_PUSH_FRONT;
        cmd.value      <= '0;
        rst_n           = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        cycle_count     = 0;
        mismatch_count  = 0;
        views_checked   = 0;
        pushes_sent     = 0;
        pops_sent       = 0;
        rejects_sent    = 0;
        full_reached    = 0;
        ring_head       = 0;
        ring_fill       = 0;
        for (i = 0; i < DEPTH; i++)
        begin
            ring_mem[i] = '0;
        end

        max_val   = 32'sh7FFFFFFF;
        min_val   = 32'sh80000000;
        none      = '0;
        empty_err = '{front_value: '0, back_value: '0, entry_count: 5'd0,
                      is_empty: 1'b1, is_full: 1'b0, op_error: 1'b1};

        add_row(OP_POP_FRONT, 32'sd7, 1'b1, empty_err);
        add_row(OP_POP_BACK, -32'sd7, 1'b1, empty_err);
        add_row(OP_PUSH_BACK, max_val, 1'b1,
                '{max_val, max_val, 5'd1, 1'b0, 1'b0, 1'b0});
        add_row(OP_PUSH_FRONT, min_val, 1'b1,
                '{min_val, max_val, 5'd2, 1'b0, 1'b0, 1'b0});
        add_row(OP_POP_BACK, 32'sd0, 1'b1,
                '{min_val, min_val, 5'd1, 1'b0, 1'b0, 1'b0});
        add_row(OP_POP_FRONT, 32'sd0, 1'b1,
                '{32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0, 1'b0});
        add_row(OP_PUSH_FRONT, -32'sd1, 1'b1,
                '{-32'sd1, -32'sd1, 5'd1, 1'b0, 1'b0, 1'b0});
        for (i = 0; i < DEPTH - 2; i++)
        begin
            add_row(OP_PUSH_BACK, (i % 2 == 0) ? 32'sh55555555 : 32'shAAAAAAAA + i,
                    1'b0, none);
        end
        add_row(OP_PUSH_FRONT, 32'sd0, 1'b0, none);
        add_row(OP_PUSH_BACK, 32'sd1, 1'b0, none);
        add_row(OP_PUSH_FRONT, 32'sd2, 1'b0, none);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[r])
        begin
            send_transaction(stim_table[r].op, stim_table[r].value,
                             stim_table[r].typed, stim_table[r].want);
        end
        wait_for_drain();

        push_bias  = 50;
        burst_left = 0;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(48, 16);
                    case ($urandom_range(2))
                        0: push_bias = 15;
                        1: push_bias = 50;
                        default: push_bias = 85;
                    endcase
                end
                burst_left--;
                if ($urandom_range(99) < push_bias)
                begin
                    op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end
                else
                begin
                    op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                end
                case ($urandom_range(15))
                    0: value = max_val;
                    1: value = min_val;
                    2: value = -32'sd1;
                    3: value = 32'sd0;
                    default: value = $urandom;
                endcase
                send_transaction(op, value, 1'b0, none);
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pushes and %0d pops, %0d of them rejected at full or empty,",
                 pushes_sent, pops_sent, rejects_sent);
        $display("with the deque full after %0d transactions; %0d results checked.",
                 full_reached, views_checked);
        if (mismatch_count == 0 && expected_views.size() == 0)
        begin
            $display("bounded_double_ended_queue_tb: done, clean");
        end
        else
        begin
            $display("bounded_double_ended_queue_tb: done, errors");
        end
        $finish;
    end

endmodule
